/* hw/rtl/adc_avg_pkg.sv */
// ----------------------------------------------------------------------------
// ADC average display package
// Shared widths, display constants and the seven-segment digit table.
// ----------------------------------------------------------------------------
`default_nettype none

package adc_avg_pkg;

	// Field widths
	localparam int SAMPLE_W = 10;
	localparam int SCALED_W = 12;
	localparam int AVG_W    = 12;
	localparam int SEG_W    = 8;
	localparam int DIGIT_W  = 4;

	// Largest value that fits on three digits
	localparam logic [AVG_W-1:0] DISPLAY_LIMIT = 12'd999;

	// Lit-segment patterns, bit0 = a .. bit6 = g, bit7 = dp
	localparam logic [SEG_W-1:0] SEG_E  = 8'h79;
	localparam logic [SEG_W-1:0] SEG_R  = 8'h50;
	localparam logic [SEG_W-1:0] DP_BIT = 8'h80;

	// Decimal digit to lit segments; codes above nine light nothing
	function automatic logic [SEG_W-1:0] seg_lit(input logic [DIGIT_W-1:0] digit);
		logic [SEG_W-1:0] lit;
		case (digit)
			4'd0:    lit = 8'h3F;
			4'd1:    lit = 8'h06;
			4'd2:    lit = 8'h5B;
			4'd3:    lit = 8'h4F;
			4'd4:    lit = 8'h66;
			4'd5:    lit = 8'h6D;
			4'd6:    lit = 8'h7D;
			4'd7:    lit = 8'h07;
			4'd8:    lit = 8'h7F;
			4'd9:    lit = 8'h6F;
			default: lit = 8'h00;
		endcase
		return lit;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/adc_average_seven_segment_unit.sv */
// ----------------------------------------------------------------------------
// ADC moving average with seven-segment readout
// Scales 10-bit converter samples to tenths of a volt, averages the last
// WINDOW_DEPTH of them and decodes the average to three display bytes.
// ----------------------------------------------------------------------------
// One item is one converter sample; it yields exactly one result item carrying
// the averaged voltage in 0.1 V units and three active-low seven-segment bytes
// (hundreds, tens, units) with the decimal point lit on the tens digit. Averages
// above 999 show "Err" (decimal point still lit) while voltage_tenths keeps the
// true value. The ring of scaled samples starts at zero, so the first
// WINDOW_DEPTH-1 results average in zeros. Throughput is one item per clock
// while result_stall is low; a sample reaches result_valid through five
// registers: input register, running-sum update against the ring memory,
// reciprocal multiply for the divide by WINDOW_DEPTH, constant-multiply digit
// split, then segment decode into the result register. The ring is a
// single-port-write, single-read memory whose next slot is read ahead;
// no clearing pass is needed since a fill flag masks slots not yet written. A
// stalled result holds in the result register and earlier stages keep filling
// any bubbles behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_average_seven_segment_unit
	import adc_avg_pkg::*;
#(
	parameter int WINDOW_DEPTH = 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,

	input  wire logic                sample_valid,
	output logic                     sample_stall,
	input  wire logic [SAMPLE_W-1:0] adc_sample,

	output logic                     result_valid,
	input  wire logic                result_stall,
	output logic [AVG_W-1:0]         voltage_tenths,
	output logic [SEG_W-1:0]         seg_hundreds,
	output logic [SEG_W-1:0]         seg_tens,
	output logic [SEG_W-1:0]         seg_units
);

	// Derived sizes
	localparam int PTR_W   = $clog2(WINDOW_DEPTH);
	localparam int SUM_W   = SCALED_W + PTR_W;
	// divide by WINDOW_DEPTH as multiply by a rounded-up reciprocal, exact
	// for any sum below 2**SUM_W
	localparam int SH      = SUM_W + PTR_W;
	localparam int RECIP_W = SUM_W + 1;
	localparam int PROD_W  = SUM_W + RECIP_W;
	localparam longint unsigned RECIP_FULL =
		((longint'(1) << SH) + longint'(WINDOW_DEPTH) - 1) / longint'(WINDOW_DEPTH);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(WINDOW_DEPTH - 1);

	// Stage valids
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_q;
	logic en_s1, en_s2, en_s3, en_s4, en_out;
	logic adv_s1;

	// Payload registers
	logic [SAMPLE_W-1:0] sample_s1;
	logic [SUM_W-1:0]    sum_q;
	logic [AVG_W-1:0]    avg_s3;
	logic [AVG_W-1:0]    avg_s4;
	logic [DIGIT_W-1:0]  hund_s4;
	logic [6:0]          q10_s4;
	logic                err_s4;

	// Ring memory and pointer
	logic [SCALED_W-1:0] ring_mem [WINDOW_DEPTH];
	logic [SCALED_W-1:0] rd_q;
	logic [PTR_W-1:0]    wp_q;
	logic [PTR_W-1:0]    wp_next;
	logic [PTR_W-1:0]    rd_addr;
	logic                full_q;

	// Datapath nets
	logic [SCALED_W-1:0] scaled;
	logic [SCALED_W-1:0] oldest;
	logic [SUM_W-1:0]    sum_next;
	logic [PROD_W-1:0]   prod;
	logic [15:0]         hund_prod;
	logic [17:0]         q10_prod;
	logic [6:0]          tens_full;
	logic [9:0]          units_full;
	logic [SEG_W-1:0]    lit_h, lit_t, lit_u;

	// Flow control: a stage loads when it is empty or its content moves on
	assign en_out = !valid_q || !result_stall;
	assign en_s4  = !valid_s4 || en_out;
	assign en_s3  = !valid_s3 || en_s4;
	assign en_s2  = !valid_s2 || en_s3;
	assign en_s1  = !valid_s1 || en_s2;
	assign adv_s1 = valid_s1 && en_s2;

	assign sample_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (en_s1)  valid_s1 <= sample_valid;
			if (en_s2)  valid_s2 <= valid_s1;
			if (en_s3)  valid_s3 <= valid_s2;
			if (en_s4)  valid_s4 <= valid_s3;
			if (en_out) valid_q  <= valid_s4;
		end
	end

	// Stage 1: input register
	always_ff @(posedge clk) begin
		if (en_s1 && sample_valid) begin
			sample_s1 <= adc_sample;
		end
	end

	// Stage 2: scale by three, swap into the ring, update running sum
	assign scaled   = {2'b00, sample_s1} + {1'b0, sample_s1, 1'b0};
	assign oldest   = full_q ? rd_q : '0;
	assign sum_next = sum_q - SUM_W'(oldest) + SUM_W'(scaled);
	assign wp_next  = (wp_q == LAST_SLOT) ? '0 : wp_q + 1'b1;
	// read ahead: after a write the next slot is already waiting in rd_q
	assign rd_addr  = adv_s1 ? wp_next : wp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			wp_q   <= '0;
			full_q <= 1'b0;
		end else if (adv_s1) begin
			sum_q <= sum_next;
			wp_q  <= wp_next;
			if (wp_q == LAST_SLOT) full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			ring_mem[wp_q] <= scaled;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= ring_mem[rd_addr];
	end

	// Stage 3: average by reciprocal multiply
	assign prod = sum_q * RECIP;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			avg_s3 <= prod[SH +: AVG_W];
		end
	end

	// Stage 4: hundreds and value/10 by constant multiplies, exact below 1000
	assign hund_prod = avg_s3[9:0] * 6'd41;
	assign q10_prod  = avg_s3[9:0] * 8'd205;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			avg_s4  <= avg_s3;
			hund_s4 <= hund_prod[15:12];
			q10_s4  <= q10_prod[17:11];
			err_s4  <= avg_s3 > DISPLAY_LIMIT;
		end
	end

	// Stage 5: remainders and segment decode into the result register
	assign tens_full  = q10_s4 - {hund_s4, 3'b000} - {2'b00, hund_s4, 1'b0};
	assign units_full = avg_s4[9:0] - {q10_s4, 3'b000} - {2'b00, q10_s4, 1'b0};

	always_comb begin
		if (err_s4) begin
			lit_h = SEG_E;
			lit_t = SEG_R;
			lit_u = SEG_R;
		end else begin
			lit_h = seg_lit(hund_s4);
			lit_t = seg_lit(tens_full[DIGIT_W-1:0]);
			lit_u = seg_lit(units_full[DIGIT_W-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && valid_s4) begin
			voltage_tenths <= avg_s4;
			seg_hundreds   <= ~lit_h;
			seg_tens       <= ~(lit_t | DP_BIT);
			seg_units      <= ~lit_u;
		end
	end

	assign result_valid = valid_q;

endmodule

`default_nettype wire
